// ===== sv/can_node_heartbeat_supervisor_defines.svh =====
// Assertion macros shared by the supervisor RTL.
`ifndef CAN_NODE_HEARTBEAT_SUPERVISOR_DEFINES_SVH
`define CAN_NODE_HEARTBEAT_SUPERVISOR_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define CHB_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CHB_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

`endif

// ===== sv/chb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chb_pkg
// Types and constants shared by the heartbeat supervisor modules.
// ----------------------------------------------------------------------------
package chb_pkg;

  localparam int NODE_COUNT_DEF    = 8;
  localparam int ERROR_ENTRIES_DEF = 16;

  localparam logic [10:0] HB_ID_RESET      = 11'd769;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd1500;
  localparam logic [15:0] PERIOD_RESET     = 16'd500;

  // configuration register indexes
  localparam logic [2:0] REG_BUS_STARTED = 3'd0;
  localparam logic [2:0] REG_HB_ID       = 3'd1;
  localparam logic [2:0] REG_OWN_NODE    = 3'd2;
  localparam logic [2:0] REG_TIMEOUT     = 3'd3;
  localparam logic [2:0] REG_PERIOD      = 3'd4;

  // item kinds
  localparam logic [1:0] OP_RX    = 2'd0;
  localparam logic [1:0] OP_TX    = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // error entry kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TX   = 2'd1;
  localparam logic [1:0] KIND_RX   = 2'd2;
  localparam logic [1:0] KIND_HB   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_RXCLR,
    ST_TXOP,
    ST_SCHED,
    ST_NODE,
    ST_NODEERR,
    ST_COUNT,
    ST_DONE
  } state_t;

  // request to the error table search unit
  typedef struct packed {
    logic        go;
    logic        set;   // 1 set, 0 clear
    logic [11:0] id;
    logic [1:0]  kind;
  } err_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
  } err_sts_t;

endpackage

// ===== sv/chb_err_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chb_err_table
// Error table: sequential search by identifier, set/clear/append, and a
// count pass of active entries, one entry per cycle.
// ----------------------------------------------------------------------------
`include "can_node_heartbeat_supervisor_defines.svh"
module chb_err_table import chb_pkg::*; #(
  parameter int ERROR_ENTRIES = ERROR_ENTRIES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  err_req_t req,
  input  logic     cnt_go,
  output err_sts_t sts,
  output logic     cnt_done,
  output logic [4:0] active_cnt
);

  localparam int IW = (ERROR_ENTRIES > 1) ? $clog2(ERROR_ENTRIES) : 1;
  localparam int UW = $clog2(ERROR_ENTRIES + 1);

  logic [11:0] id_r [ERROR_ENTRIES];
  logic [1:0]  kind_r [ERROR_ENTRIES];
  logic [ERROR_ENTRIES-1:0] act_r, act_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] idx_r, idx_nxt;
  logic srch_r, srch_nxt, cnt_r, cnt_nxt, done_r, done_nxt, cdone_r, cdone_nxt;
  logic set_r;
  logic [11:0] rid_r;
  logic [1:0]  rkind_r;
  logic [4:0]  acc_r, acc_nxt;
  logic [IW-1:0] ix;
  logic hit, wr_en, app;
  logic [IW-1:0] wr_ix;

  assign ix = idx_r[IW-1:0];
  assign hit = (idx_r < used_r) && (id_r[ix] == rid_r) &&
               (set_r || (act_r[ix] && kind_r[ix] == rkind_r));
  assign app = srch_r && !(idx_r < used_r) && set_r &&
               (used_r < UW'(ERROR_ENTRIES));
  assign wr_en = srch_r && ((idx_r < used_r && hit) || app);
  assign wr_ix = app ? used_r[IW-1:0] : ix;

  // sequencer for search and count
  always_comb begin
    srch_nxt = srch_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    done_nxt = 1'b0;
    cdone_nxt = 1'b0;
    act_nxt = act_r;
    used_nxt = used_r;
    acc_nxt = acc_r;
    if (req.go) begin
      srch_nxt = 1'b1;
      idx_nxt = '0;
    end else if (cnt_go) begin
      cnt_nxt = 1'b1;
      idx_nxt = '0;
      acc_nxt = '0;
    end else if (srch_r) begin
      if (wr_en || !(idx_r < used_r)) begin
        srch_nxt = 1'b0;
        done_nxt = 1'b1;
        if (wr_en) act_nxt[wr_ix] = set_r;
        if (app) used_nxt = used_r + 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end else if (cnt_r) begin
      if (!(idx_r < used_r)) begin
        cnt_nxt = 1'b0;
        cdone_nxt = 1'b1;
      end else begin
        if (act_r[ix] && acc_r != 5'd31) acc_nxt = acc_r + 5'd1;
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r <= 1'b0;
      cnt_r <= 1'b0;
      done_r <= 1'b0;
      cdone_r <= 1'b0;
      act_r <= '0;
      used_r <= '0;
      idx_r <= '0;
      acc_r <= '0;
    end else begin
      srch_r <= srch_nxt;
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
      cdone_r <= cdone_nxt;
      act_r <= act_nxt;
      used_r <= used_nxt;
      idx_r <= idx_nxt;
      acc_r <= acc_nxt;
    end
  end

  // latch request and write entry payload
  always_ff @(posedge clk) begin
    if (req.go) begin
      set_r <= req.set;
      rid_r <= req.id;
      rkind_r <= req.kind;
    end
    if (!req.go && !cnt_go && wr_en) begin
      id_r[wr_ix] <= rid_r;
      kind_r[wr_ix] <= set_r ? rkind_r : KIND_NONE;
    end
  end

  assign sts.busy = srch_r;
  assign sts.done = done_r;
  assign cnt_done = cdone_r;
  assign active_cnt = acc_r;

  `CHB_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_r <= UW'(ERROR_ENTRIES),
    "error table fill count beyond depth")
  `CHB_ASSERT_IMP(a_not_both, clk, rst_n, 1'b1, !(srch_r && cnt_r),
    "search and count running together")
  `CHB_ASSERT_NXT(a_app_grows, clk, rst_n, app && !req.go && !cnt_go,
    used_r == $past(used_r) + 1'b1, "append did not grow table")

endmodule

// ===== sv/can_node_heartbeat_supervisor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_node_heartbeat_supervisor
// Each word passes through a divide by ten and dispatch, a walk over the nodes in a
// check, error-table searches, and a count pass over the error table.
// Throughput: one word at a time; busy stays high until out_valid strobes.
// The single error-table search unit serves every search and the count pass.
// Reset is synchronous, active low; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "can_node_heartbeat_supervisor_defines.svh"
module can_node_heartbeat_supervisor import chb_pkg::*; #(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ERROR_ENTRIES = ERROR_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_now_ms,
  input  logic [10:0] in_frame_id,
  input  logic [3:0]  in_frame_len,
  input  logic [7:0]  in_node_byte,
  input  logic        in_tx_ok,
  output logic        out_valid,
  output logic        out_alarm_on,
  output logic        out_heartbeat_due,
  output logic [28:0] out_uptime_centis,
  output logic [7:0]  out_alive_mask,
  output logic [4:0]  out_active_errors,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int NCW = $clog2(NODE_COUNT + 1);
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

  // configuration
  logic bus_r;
  logic [10:0] hb_id_r;
  logic [7:0] own_r;
  logic [15:0] tmo_r, per_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= 1'b0;
      hb_id_r <= HB_ID_RESET;
      own_r <= '0;
      tmo_r <= TIMEOUT_RESET;
      per_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUS_STARTED: bus_r <= cfg_data[0];
        REG_HB_ID:       hb_id_r <= cfg_data[10:0];
        REG_OWN_NODE:    own_r <= cfg_data[7:0];
        REG_TIMEOUT:     tmo_r <= cfg_data;
        REG_PERIOD:      per_r <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t st_r, st_nxt;
  logic [1:0] op_r;
  logic [31:0] now_r;
  logic [10:0] fid_r;
  logic [3:0] flen_r;
  logic [7:0] nb_r;
  logic ok_r;

  logic [31:0] seen_t_r [NODE_COUNT];
  logic [NODE_COUNT-1:0] seen_r, seen_nxt, alive_r, alive_nxt;
  logic [31:0] nst_r, nst_nxt;
  logic sched_r, sched_nxt, due_r, due_nxt;
  logic [NCW-1:0] n_r, n_nxt;
  logic [NW-1:0] nix;
  logic [31:0] age;
  logic node_alive;
  logic [31:0] nst_base, lag;

  // divide by ten through a reciprocal multiplication
  logic [28:0] dq_r, dq_nxt;
  logic [63:0] prod;

  err_req_t req;
  err_sts_t ests;
  logic cnt_go, cnt_done;
  logic [4:0] acnt;
  logic rec_hb;

  assign nix = n_r[NW-1:0];
  assign age = now_r - seen_t_r[nix];
  assign node_alive = seen_r[nix] && (age <= {16'd0, tmo_r});
  assign prod = {32'd0, now_r} * {32'd0, DIV10_RECIP};
  assign nst_base = sched_r ? nst_r : now_r;
  assign lag = now_r - nst_base;
  assign rec_hb = (fid_r == hb_id_r) && (flen_r >= 4'd8) &&
                  ({24'd0, nb_r} < 32'(NODE_COUNT));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:    if (start) st_nxt = ST_DIV;
      ST_DIV: begin
        if (!bus_r) st_nxt = ST_COUNT;
        else if (op_r == OP_RX) st_nxt = ST_RXCLR;
        else if (op_r == OP_TX) st_nxt = ST_TXOP;
        else if (op_r == OP_CHECK) st_nxt = ST_SCHED;
        else st_nxt = ST_COUNT;
      end
      ST_RXCLR:   if (ests.done) st_nxt = ST_COUNT;
      ST_TXOP:    if (ests.done) st_nxt = ST_COUNT;
      ST_SCHED:   st_nxt = ST_NODE;
      ST_NODE: begin
        if (n_r == NCW'(NODE_COUNT)) st_nxt = ST_COUNT;
        else if ({{(32-NCW){1'b0}}, n_r} != {24'd0, own_r} &&
                 node_alive != alive_r[nix]) st_nxt = ST_NODEERR;
      end
      ST_NODEERR: if (ests.done) st_nxt = ST_NODE;
      ST_COUNT:   if (cnt_done) st_nxt = ST_DONE;
      ST_DONE:    st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    dq_nxt = dq_r;
    seen_nxt = seen_r;
    alive_nxt = alive_r;
    nst_nxt = nst_r;
    sched_nxt = sched_r;
    due_nxt = due_r;
    n_nxt = n_r;
    req = '0;
    cnt_go = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (start) due_nxt = 1'b0;
      end
      ST_DIV: begin
        dq_nxt = prod[63:35];
        if (!bus_r || !(op_r == OP_RX || op_r == OP_TX || op_r == OP_CHECK))
          cnt_go = 1'b1;
        else if (op_r == OP_RX) begin
          req.go = 1'b1; req.set = 1'b0;
          req.id = {1'b0, fid_r}; req.kind = KIND_RX;
        end else if (op_r == OP_TX) begin
          req.go = 1'b1; req.set = !ok_r;
          req.id = {1'b0, fid_r}; req.kind = KIND_TX;
        end
      end
      ST_RXCLR: begin
        if (ests.done) begin
          if (rec_hb) seen_nxt[nb_r[NW-1:0]] = 1'b1;
          cnt_go = 1'b1;
        end
      end
      ST_TXOP: if (ests.done) cnt_go = 1'b1;
      ST_SCHED: begin
        // anchor the schedule on the first check, then advance by one period when due
        nst_nxt = nst_base;
        if (!lag[31]) begin
          due_nxt = 1'b1;
          nst_nxt = nst_base + {16'd0, per_r};
        end
        sched_nxt = 1'b1;
        n_nxt = '0;
      end
      ST_NODE: begin
        if (n_r == NCW'(NODE_COUNT)) cnt_go = 1'b1;
        else if ({{(32-NCW){1'b0}}, n_r} != {24'd0, own_r} &&
                 node_alive != alive_r[nix]) begin
          alive_nxt[nix] = node_alive;
          req.go = 1'b1;
          req.set = !node_alive;
          req.id = 12'({1'b0, hb_id_r} + {{(12-NCW){1'b0}}, n_r});
          req.kind = KIND_HB;
        end else n_nxt = n_r + 1'b1;
      end
      ST_NODEERR: if (ests.done) n_nxt = n_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      seen_r <= '0;
      alive_r <= '0;
      nst_r <= '0;
      sched_r <= 1'b0;
      due_r <= 1'b0;
      n_r <= '0;
    end else begin
      st_r <= st_nxt;
      seen_r <= seen_nxt;
      alive_r <= alive_nxt;
      nst_r <= nst_nxt;
      sched_r <= sched_nxt;
      due_r <= due_nxt;
      n_r <= n_nxt;
    end
  end

  // hold the input word and record heartbeat times
  always_ff @(posedge clk) begin
    dq_r <= dq_nxt;
    if (st_r == ST_IDLE && start) begin
      op_r <= in_op;
      now_r <= in_now_ms;
      fid_r <= in_frame_id;
      flen_r <= in_frame_len;
      nb_r <= in_node_byte;
      ok_r <= in_tx_ok;
    end
    if (st_r == ST_RXCLR && ests.done && rec_hb)
      seen_t_r[nb_r[NW-1:0]] <= now_r;
  end

  chb_err_table #(.ERROR_ENTRIES(ERROR_ENTRIES)) u_err (
    .clk(clk), .rst_n(rst_n), .req(req), .cnt_go(cnt_go),
    .sts(ests), .cnt_done(cnt_done), .active_cnt(acnt)
  );

  logic [7:0] mask8;
  always_comb begin
    mask8 = '0;
    for (int i = 0; i < 8; i++)
      if (i < NODE_COUNT) mask8[i] = alive_r[i % NODE_COUNT];
  end

  assign busy = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_DONE);
  assign out_alarm_on = !bus_r || (acnt != 5'd0);
  assign out_heartbeat_due = due_r;
  assign out_uptime_centis = dq_r;
  assign out_alive_mask = mask8;
  assign out_active_errors = acnt;

  `CHB_ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid, busy,
    "result strobe outside a busy word")
  `CHB_ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid, !out_valid,
    "result strobe longer than one cycle")
  `CHB_ASSERT_IMP(a_due_check, clk, rst_n, out_valid && op_r != OP_CHECK,
    !out_heartbeat_due, "heartbeat due outside a check")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CAN node heartbeat supervisor. Sends received
// frames, transmit outcomes and periodic checks, predicts every result word
// from a behavioural copy of the node and error-table state, and compares
// each strobed word field by field.
// ----------------------------------------------------------------------------
module tb;
  import chb_pkg::*;

  localparam int NODES   = 8;
  localparam int ENTRIES = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        alarm_on;
    logic        heartbeat_due;
    logic [28:0] uptime_centis;
    logic [7:0]  alive_mask;
    logic [4:0]  active_errors;
  } status_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = OP_RX;
  logic [31:0] in_now_ms = '0;
  logic [10:0] in_frame_id = '0;
  logic [3:0]  in_frame_len = '0;
  logic [7:0]  in_node_byte = '0;
  logic        in_tx_ok = 1'b0;
  logic        out_valid;
  logic        out_alarm_on;
  logic        out_heartbeat_due;
  logic [28:0] out_uptime_centis;
  logic [7:0]  out_alive_mask;
  logic [4:0]  out_active_errors;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_BUS_STARTED;
  logic [15:0] cfg_data = '0;

  // supervisor shadow state
  logic        sh_started;
  logic [10:0] sh_hb_id;
  logic [7:0]  sh_own_node;
  logic [15:0] sh_timeout;
  logic [15:0] sh_period;
  logic [31:0] sh_last_seen [NODES];
  logic        sh_seen [NODES];
  logic        sh_alive [NODES];
  logic [11:0] sh_err_id [ENTRIES];
  logic        sh_err_act [ENTRIES];
  logic [1:0]  sh_err_kind [ENTRIES];
  int          sh_used;
  logic [31:0] sh_next_send;
  logic        sh_scheduled;

  status_word_t pending_status[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  quiet = 0;
  logic [31:0] clock_ms = 0;

  can_node_heartbeat_supervisor u_top (.*);

  always #5 clk = ~clk;

  // Error table updates
  function automatic void table_set(logic [11:0] id, logic [1:0] kind);
    for (int i = 0; i < sh_used; i++) begin
      if (sh_err_id[i] == id) begin
        sh_err_act[i] = 1'b1;
        sh_err_kind[i] = kind;
        return;
      end
    end
    if (sh_used < ENTRIES) begin
      sh_err_id[sh_used] = id;
      sh_err_act[sh_used] = 1'b1;
      sh_err_kind[sh_used] = kind;
      sh_used++;
    end
  endfunction

  function automatic void table_clear(logic [11:0] id, logic [1:0] kind);
    for (int i = 0; i < sh_used; i++) begin
      if (sh_err_id[i] == id && sh_err_act[i] && sh_err_kind[i] == kind) begin
        sh_err_act[i] = 1'b0;
        sh_err_kind[i] = KIND_NONE;
        return;
      end
    end
  endfunction

  function automatic void reset_shadow();
    sh_started = 1'b0;
    sh_hb_id = HB_ID_RESET;
    sh_own_node = '0;
    sh_timeout = TIMEOUT_RESET;
    sh_period = PERIOD_RESET;
    for (int n = 0; n < NODES; n++) begin
      sh_last_seen[n] = '0;
      sh_seen[n] = 1'b0;
      sh_alive[n] = 1'b0;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      sh_err_id[i] = '0;
      sh_err_act[i] = 1'b0;
      sh_err_kind[i] = KIND_NONE;
    end
    sh_used = 0;
    sh_next_send = '0;
    sh_scheduled = 1'b0;
  endfunction

  // Advance the shadow by one word and return the status it should report
  function automatic status_word_t supervise(logic [1:0] op, logic [31:0] now,
      logic [10:0] fid, logic [3:0] flen, logic [7:0] nb, logic ok);
    status_word_t s;
    logic alive_now;
    logic [31:0] lag;
    int cnt;
    s = '0;
    cnt = 0;
    if (sh_started) begin
      if (op == OP_RX) begin
        table_clear({1'b0, fid}, KIND_RX);
        if (fid == sh_hb_id && flen >= 4'd8 && nb < NODES) begin
          sh_last_seen[nb[2:0]] = now;
          sh_seen[nb[2:0]] = 1'b1;
        end
      end else if (op == OP_TX) begin
        if (ok) table_clear({1'b0, fid}, KIND_TX);
        else table_set({1'b0, fid}, KIND_TX);
      end else if (op == OP_CHECK) begin
        if (!sh_scheduled) begin
          sh_next_send = now;
          sh_scheduled = 1'b1;
        end
        lag = now - sh_next_send;
        if (!lag[31]) begin
          s.heartbeat_due = 1'b1;
          sh_next_send = sh_next_send + sh_period;
        end
        for (int n = 0; n < NODES; n++) begin
          if (n == sh_own_node) continue;
          lag = now - sh_last_seen[n];
          alive_now = sh_seen[n] && lag <= {16'd0, sh_timeout};
          if (alive_now != sh_alive[n]) begin
            sh_alive[n] = alive_now;
            if (alive_now) table_clear({1'b0, sh_hb_id} + 12'(n), KIND_HB);
            else table_set({1'b0, sh_hb_id} + 12'(n), KIND_HB);
          end
        end
      end
    end
    for (int i = 0; i < sh_used; i++) if (sh_err_act[i]) cnt++;
    for (int n = 0; n < NODES; n++) s.alive_mask[n] = sh_alive[n];
    s.alarm_on = !sh_started || cnt > 0;
    s.uptime_centis = 29'(now / 10);
    s.active_errors = 5'(cnt);
    return s;
  endfunction

  // Write one register, block idle
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BUS_STARTED: sh_started = value[0];
      REG_HB_ID:       sh_hb_id = value[10:0];
      REG_OWN_NODE:    sh_own_node = value[7:0];
      REG_TIMEOUT:     sh_timeout = value;
      REG_PERIOD:      sh_period = value;
      default: ;
    endcase
  endtask

  // Drain outstanding words before touching registers
  task automatic settle();
    while (pending_status.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Send one word, with random idle gaps unless quiet is set
  task automatic send_word(logic [1:0] op, logic [31:0] now, logic [10:0] fid,
      logic [3:0] flen, logic [7:0] nb, logic ok);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 17) @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1'b1;
    in_op <= op;
    in_now_ms <= now;
    in_frame_id <= fid;
    in_frame_len <= flen;
    in_node_byte <= nb;
    in_tx_ok <= ok;
    @(posedge clk);
    pending_status.push_back(supervise(op, now, fid, flen, nb, ok));
    @(negedge clk);
    start <= 1'b0;
    in_now_ms <= $urandom;
  endtask

  task automatic heartbeat(logic [7:0] node, logic [31:0] now);
    send_word(OP_RX, now, sh_hb_id, 4'd8, node, 1'b0);
  endtask

  // Compare each strobed word with the oldest prediction
  always @(posedge clk) begin
    status_word_t want;
    if (rst_n && out_valid) begin
      if (pending_status.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = pending_status.pop_front();
        if (out_alarm_on !== want.alarm_on) begin
          $error("alarm_on exp %0d got %0d", want.alarm_on, out_alarm_on);
          fail_count++;
        end
        if (out_heartbeat_due !== want.heartbeat_due) begin
          $error("heartbeat_due exp %0d got %0d", want.heartbeat_due, out_heartbeat_due);
          fail_count++;
        end
        if (out_uptime_centis !== want.uptime_centis) begin
          $error("uptime_centis exp %0d got %0d", want.uptime_centis, out_uptime_centis);
          fail_count++;
        end
        if (out_alive_mask !== want.alive_mask) begin
          $error("alive_mask exp %h got %h", want.alive_mask, out_alive_mask);
          fail_count++;
        end
        if (out_active_errors !== want.active_errors) begin
          $error("active_errors exp %0d got %0d", want.active_errors, out_active_errors);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with nothing accepted
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stopped bus: nothing changes, alarm held on
  task automatic test_bus_stopped();
    heartbeat(8'd1, 32'd100);
    send_word(OP_TX, 32'd200, 11'd5, 4'd0, 8'd0, 1'b0);
    send_word(OP_CHECK, 32'd300, 11'd0, 4'd0, 8'd0, 1'b0);
    send_word(2'd3, 32'hFFFF_FFFF, 11'h7FF, 4'hF, 8'hFF, 1'b1);
    settle();
  endtask

  // Directed corners: extremes, every kind, never seen, wrap, zero time
  task automatic test_directed();
    write_reg(REG_BUS_STARTED, 16'd1);
    send_word(OP_CHECK, 32'd0, 11'd0, 4'd0, 8'd0, 1'b0);
    heartbeat(8'd1, 32'd0);
    heartbeat(8'd7, 32'd10);
    send_word(OP_RX, 32'd20, sh_hb_id, 4'd7, 8'd2, 1'b0);
    send_word(OP_RX, 32'd25, sh_hb_id, 4'hF, 8'd3, 1'b1);
    send_word(OP_RX, 32'd26, sh_hb_id, 4'd8, 8'd8, 1'b0);
    send_word(OP_RX, 32'd27, sh_hb_id, 4'd8, 8'hFF, 1'b0);
    send_word(OP_CHECK, 32'd499, 11'd0, 4'd0, 8'd0, 1'b0);
    send_word(OP_CHECK, 32'd500, 11'd0, 4'd0, 8'd0, 1'b0);
    send_word(OP_TX, 32'd600, 11'h7FF, 4'd0, 8'd0, 1'b0);
    send_word(OP_TX, 32'd610, 11'h7FF, 4'd0, 8'd0, 1'b1);
    send_word(OP_TX, 32'd620, 11'd0, 4'd0, 8'd0, 1'b0);
    send_word(OP_RX, 32'd630, 11'd0, 4'd0, 8'd0, 1'b0);
    send_word(OP_CHECK, 32'd5000, 11'd0, 4'd0, 8'd0, 1'b0);
    heartbeat(8'd1, 32'hFFFF_FFF0);
    send_word(OP_CHECK, 32'h0000_0010, 11'd0, 4'd0, 8'd0, 1'b0);
    send_word(2'd3, 32'hFFFF_FFFF, 11'h7FF, 4'hF, 8'hFF, 1'b1);
    for (int i = 0; i < 18; i++)
      send_word(OP_TX, 32'd700 + i, 11'(100 + i), 4'd0, 8'd0, 1'b0);
    settle();
  endtask

  // Register extremes: zero then full timeout and period, top then zero ids, own node out of range
  task automatic test_register_extremes();
    write_reg(REG_TIMEOUT, 16'd0);
    write_reg(REG_PERIOD, 16'd0);
    write_reg(REG_HB_ID, 16'h07FF);
    write_reg(REG_OWN_NODE, 16'd255);
    heartbeat(8'd0, 32'd9000);
    send_word(OP_CHECK, 32'd9000, 11'd0, 4'd0, 8'd0, 1'b0);
    send_word(OP_CHECK, 32'd9001, 11'd0, 4'd0, 8'd0, 1'b0);
    settle();
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_PERIOD, 16'hFFFF);
    write_reg(REG_HB_ID, 16'd0);
    write_reg(REG_OWN_NODE, 16'd7);
    heartbeat(8'd7, 32'd9100);
    heartbeat(8'd0, 32'd9100);
    send_word(OP_CHECK, 32'd9200, 11'd0, 4'd0, 8'd0, 1'b0);
    send_word(OP_CHECK, 32'd80000, 11'd0, 4'd0, 8'd0, 1'b0);
    settle();
  endtask

  // Random phases: mostly a ticking clock with heartbeats and checks
  task automatic random_phase(int words, logic [10:0] hb, logic [7:0] own,
      logic [15:0] tmo, logic [15:0] per, bit run);
    int pick;
    write_reg(REG_HB_ID, {5'd0, hb});
    write_reg(REG_OWN_NODE, {8'd0, own});
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_PERIOD, per);
    write_reg(REG_BUS_STARTED, {15'd0, run});
    clock_ms = $urandom;
    for (int k = 0; k < words; k++) begin
      quiet = (k % 300) >= 220;
      pick = $urandom_range(99);
      clock_ms = clock_ms + $urandom_range(2 * tmo / 3 + 1);
      if (pick < 40)
        heartbeat(8'($urandom_range(9)), clock_ms);
      else if (pick < 65)
        send_word(OP_CHECK, clock_ms, 11'($urandom), 4'($urandom), 8'($urandom),
                  1'($urandom));
      else if (pick < 80)
        send_word(OP_TX, clock_ms, hb + 11'($urandom_range(20)), 4'($urandom),
                  8'($urandom), 1'($urandom));
      else if (pick < 92)
        send_word(OP_RX, clock_ms, hb + 11'($urandom_range(20)), 4'($urandom),
                  8'($urandom), 1'($urandom));
      else
        send_word(2'($urandom), $urandom, 11'($urandom), 4'($urandom),
                  8'($urandom), 1'($urandom));
    end
    quiet = 0;
    settle();
  endtask

  initial begin
    reset_shadow();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_bus_stopped();
    test_directed();
    test_register_extremes();
    random_phase(500, HB_ID_RESET, 8'd0, 16'd1500, 16'd500, 1'b1);
    random_phase(400, 11'($urandom), 8'($urandom_range(7)), 16'd40, 16'd1, 1'b1);
    random_phase(400, 11'h7F0, 8'd200, 16'd3, 16'd20, 1'b1);
    random_phase(100, 11'd5, 8'd3, 16'd300, 16'd100, 1'b0);
    random_phase(400, 11'd0, 8'd4, 16'hFFFF, 16'hFFFF, 1'b1);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_status.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
